### design/cdda_pkg.sv
`timescale 1ns / 1ps
// Shared widths, command and result types for the clipped DDA line rasterizer.
package cdda_pkg;

	localparam int COORD_W     = 16;  // input coordinate
	localparam int DELTA_W     = 17;  // end - begin
	localparam int MAG_W       = 16;  // |delta|, at most 65535
	localparam int SQ_W        = 32;  // |delta|^2
	localparam int SUM_W       = 33;  // dx^2 + dy^2, odd so the top root bit sits at an even place
	localparam int FRAC_W      = 16;  // fraction bits of the Q18.16 position and Q2.16 increment
	localparam int POS_W       = 34;  // Q18.16 position
	localparam int STEP_W      = 18;  // Q2.16 increment
	localparam int COUNT_W     = 17;  // step count, also the root width
	localparam int COLOR_W     = 32;
	localparam int PIX_W       = 10;
	localparam int QUEUE_DEPTH = 2;

	localparam int IN_DATA_W   = 4 * COORD_W + COLOR_W;
	localparam int OUT_PAD_W   = 4;
	localparam int OUT_DATA_W  = 2 * PIX_W + COLOR_W + OUT_PAD_W;
	localparam int OUT_USER_W  = 2;

	typedef enum logic [1:0] {
		CMD_STEP,
		CMD_START,
		CMD_START_NULL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic signed [COORD_W-1:0]   begin_x;
		logic signed [COORD_W-1:0]   begin_y;
		logic signed [DELTA_W-1:0]   delta_x;
		logic signed [DELTA_W-1:0]   delta_y;
		logic        [COLOR_W-1:0]   color;
	} cdda_cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               write;
		logic               last;
		logic               busy;
	} pix_res_t;

endpackage

### design/cdda_front.sv
`timescale 1ns / 1ps
// Front end: unpacks input beats, forms deltas and classifies them into commands.
module cdda_front (
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [cdda_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tuser,
	input  logic                               queue_full,
	output logic                               push,
	output cdda_pkg::cdda_cmd_t                cmd
);
	import cdda_pkg::*;

	logic signed [COORD_W-1:0] bx, by, ex, ey;
	logic signed [DELTA_W-1:0] dx, dy;

	assign bx = s_axis_tdata[0*COORD_W +: COORD_W];
	assign by = s_axis_tdata[1*COORD_W +: COORD_W];
	assign ex = s_axis_tdata[2*COORD_W +: COORD_W];
	assign ey = s_axis_tdata[3*COORD_W +: COORD_W];

	assign dx = DELTA_W'(ex) - DELTA_W'(bx);
	assign dy = DELTA_W'(ey) - DELTA_W'(by);

	always_comb begin
		cmd.begin_x = bx;
		cmd.begin_y = by;
		cmd.delta_x = dx;
		cmd.delta_y = dy;
		cmd.color   = s_axis_tdata[4*COORD_W +: COLOR_W];
		if (s_axis_tuser) begin
			cmd.kind = CMD_STEP;
		end else if (dx == '0 && dy == '0) begin
			cmd.kind = CMD_START_NULL;
		end else begin
			cmd.kind = CMD_START;
		end
	end

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

endmodule

### design/cdda_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module cdda_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cdda_pkg::cdda_cmd_t   cmd_in,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output cdda_pkg::cdda_cmd_t   head
);
	import cdda_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cdda_cmd_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/cdda_root.sv
`timescale 1ns / 1ps
// Bit-serial integer square root, one result bit per cycle.
module cdda_root (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cdda_pkg::SUM_W-1:0]      value,
	output logic                            done,
	output logic [cdda_pkg::COUNT_W-1:0]    root
);
	import cdda_pkg::*;

	logic [SUM_W-1:0] v_q, res_q, bit_q;
	logic             done_q;
	logic [SUM_W:0]   trial;
	logic             take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = ({1'b0, v_q} >= trial);

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (take) begin
				v_q   <= v_q - trial[SUM_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// last iteration runs with the lowest bit
			done_q <= !start && bit_q[0];
			if (start) begin
				bit_q <= {1'b1, {(SUM_W-1){1'b0}}};
			end else if (bit_q != '0) begin
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[COUNT_W-1:0];

endmodule

### design/cdda_div.sv
`timescale 1ns / 1ps
// Restoring divider for delta * 2^16 / n, one fraction bit per cycle, |delta| <= n.
module cdda_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cdda_pkg::DELTA_W-1:0] delta,
	input  logic [cdda_pkg::COUNT_W-1:0]        divisor,
	output logic                                done,
	output logic signed [cdda_pkg::STEP_W-1:0]  quotient
);
	import cdda_pkg::*;

	localparam int QUOT_W = FRAC_W + 1;
	localparam int CNT_W  = $clog2(FRAC_W + 1);

	logic [COUNT_W-1:0] dvs_q, rem_q;
	logic [QUOT_W-1:0]  quot_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	logic [DELTA_W-1:0] mag;
	logic               hi;
	logic [COUNT_W:0]   shifted;
	logic               ge;
	logic [STEP_W-1:0]  uquot;

	assign mag     = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
	assign hi      = (mag >= divisor);
	assign shifted = {rem_q, 1'b0};
	assign ge      = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q  <= divisor;
			neg_q  <= delta[DELTA_W-1];
			rem_q  <= hi ? (mag - divisor) : mag;
			quot_q <= {{(QUOT_W-1){1'b0}}, hi};
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? COUNT_W'(shifted - {1'b0, dvs_q}) : shifted[COUNT_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(FRAC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign uquot    = {1'b0, quot_q};
	assign quotient = neg_q ? STEP_W'(-uquot) : uquot;
	assign done     = done_q;

endmodule

### design/cdda_back.sv
`timescale 1ns / 1ps
// Back end: segment setup sequencer, DDA stepper, clip test and output register.
module cdda_back #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  cdda_pkg::cdda_cmd_t   head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cdda_pkg::pix_res_t    out_res
);
	import cdda_pkg::*;

	typedef enum logic [2:0] {
		IDLE_ST,
		SQUARE_ST,
		SUM_ST,
		ROOT_ST,
		DIVIDE_ST,
		FINISH_ST
	} state_t;

	localparam logic signed [POS_W-1:0] CLIP_LO   = POS_W'(1 << FRAC_W);
	localparam logic signed [POS_W-1:0] CLIP_X_HI = POS_W'((SCREEN_WIDTH - 1) << FRAC_W);
	localparam logic signed [POS_W-1:0] CLIP_Y_HI = POS_W'((SCREEN_HEIGHT - 1) << FRAC_W);

	state_t                    state_q;
	logic                      out_valid_q;
	pix_res_t                  out_q;
	logic signed [POS_W-1:0]   pos_x_q, pos_y_q;
	logic signed [STEP_W-1:0]  step_x_q, step_y_q;
	logic [COUNT_W-1:0]        steps_left_q;
	logic [COLOR_W-1:0]        color_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;

	logic                      out_free;
	logic                      out_load;
	logic [MAG_W-1:0]          mag_x, mag_y;
	logic [SUM_W-1:0]          sum;
	logic                      root_done, div_start, div_done_x, div_done_y;
	logic [COUNT_W-1:0]        root_n;
	logic signed [STEP_W-1:0]  quot_x, quot_y;
	logic                      in_win;
	pix_res_t                  step_res, start_res, null_res, idle_res;
	logic signed [POS_W-1:0]   head_pos_x, head_pos_y;
	logic                      steps_load;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == IDLE_ST) && head_valid && out_free;
	assign div_start = (state_q == ROOT_ST) && root_done;

	// a start beat's result waits until setup is done
	assign out_load  = (pop && head.kind != CMD_START) || (state_q == FINISH_ST && out_free);

	assign mag_x = dx_q[DELTA_W-1] ? MAG_W'(-dx_q) : MAG_W'(dx_q);
	assign mag_y = dy_q[DELTA_W-1] ? MAG_W'(-dy_q) : MAG_W'(dy_q);
	assign sum   = SUM_W'(sqx_q) + SUM_W'(sqy_q);

	assign head_pos_x = {{(POS_W-COORD_W-FRAC_W){head.begin_x[COORD_W-1]}},
	                     head.begin_x, {FRAC_W{1'b0}}};
	assign head_pos_y = {{(POS_W-COORD_W-FRAC_W){head.begin_y[COORD_W-1]}},
	                     head.begin_y, {FRAC_W{1'b0}}};

	assign in_win = (pos_x_q > CLIP_LO) && (pos_x_q < CLIP_X_HI)
	             && (pos_y_q > CLIP_LO) && (pos_y_q < CLIP_Y_HI);

	always_comb begin
		idle_res = '0;

		step_res       = '0;
		step_res.write = in_win;
		if (in_win) begin
			step_res.x     = pos_x_q[FRAC_W +: PIX_W];
			step_res.y     = pos_y_q[FRAC_W +: PIX_W];
			step_res.color = color_q;
		end
		step_res.last = (steps_left_q == COUNT_W'(1));
		step_res.busy = (steps_left_q != COUNT_W'(1));

		null_res      = '0;
		null_res.last = 1'b1;

		start_res      = '0;
		start_res.busy = 1'b1;
	end

	// Start-of-segment loads count; anything else may only count down by one.
	assign steps_load = (state_q == FINISH_ST && out_free)
	                 || (pop && head.kind == CMD_START_NULL);

	cdda_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == SUM_ST),
		.value  (sum),
		.done   (root_done),
		.root   (root_n)
	);

	cdda_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.delta    (dx_q),
		.divisor  (root_n),
		.done     (div_done_x),
		.quotient (quot_x)
	);

	cdda_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.delta    (dy_q),
		.divisor  (root_n),
		.done     (div_done_y),
		.quotient (quot_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE_ST;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			steps_left_q <= '0;
			color_q      <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			sqx_q        <= '0;
			sqy_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE_ST: begin
					if (pop) begin
						unique case (head.kind)
							CMD_STEP: begin
								if (steps_left_q != '0) begin
									out_q        <= step_res;
									pos_x_q      <= pos_x_q + POS_W'(step_x_q);
									pos_y_q      <= pos_y_q + POS_W'(step_y_q);
									steps_left_q <= steps_left_q - COUNT_W'(1);
								end else begin
									out_q <= idle_res;
								end
							end
							CMD_START_NULL: begin
								out_q        <= null_res;
								pos_x_q      <= head_pos_x;
								pos_y_q      <= head_pos_y;
								color_q      <= head.color;
								step_x_q     <= '0;
								step_y_q     <= '0;
								steps_left_q <= '0;
							end
							CMD_START: begin
								// result waits until setup is done
								pos_x_q     <= head_pos_x;
								pos_y_q     <= head_pos_y;
								color_q     <= head.color;
								dx_q        <= head.delta_x;
								dy_q        <= head.delta_y;
								state_q     <= SQUARE_ST;
							end
							default: begin
								out_q <= idle_res;
							end
						endcase
					end
				end
				SQUARE_ST: begin
					sqx_q   <= SQ_W'(mag_x) * SQ_W'(mag_x);
					sqy_q   <= SQ_W'(mag_y) * SQ_W'(mag_y);
					state_q <= SUM_ST;
				end
				SUM_ST: begin
					state_q <= ROOT_ST;
				end
				ROOT_ST: begin
					if (root_done) begin
						state_q <= DIVIDE_ST;
					end
				end
				DIVIDE_ST: begin
					if (div_done_x) begin
						state_q <= FINISH_ST;
					end
				end
				FINISH_ST: begin
					if (out_free) begin
						out_q        <= start_res;
						step_x_q     <= quot_x;
						step_y_q     <= quot_y;
						steps_left_q <= root_n;
						state_q      <= IDLE_ST;
					end
				end
				default: begin
					state_q <= IDLE_ST;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	a_root_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ROOT_ST)
		else $error("root finished outside root phase");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_x == div_done_y)
		else $error("axis dividers out of step");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		!steps_load |=> (steps_left_q == $past(steps_left_q))
			|| (steps_left_q == $past(steps_left_q) - COUNT_W'(1)))
		else $error("step count jumped without a segment load");

	a_write_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.write |-> (out_q.last != out_q.busy))
		else $error("written pixel has inconsistent last/busy");

	a_no_pop_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE_ST |-> !pop)
		else $error("queue popped during segment setup");

endmodule

### design/clipped_dda_line_rasterizer.sv
`timescale 1ns / 1ps
// Top level of the clipped DDA line rasterizer: front end, command queue, back end.
// Step beat: result goes through the queue to the output register, one pixel per cycle sustained
// while m_axis_tready is high. Start beat: the output register is loaded after the square,
//   sum, bit-serial square root and restoring divide (both axes in parallel) steps.
// The front end keeps taking beats into a 2-entry queue, until it is full, while the back end works.
// Reset (arst_n low, asynchronous): queue empty, no segment active, position,
//   increments, count and color cleared, no result pending.
module clipped_dda_line_rasterizer #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input beats
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// begin_x, begin_y, end_x, end_y (16 bits each, signed), line_color (32)
	input  logic [cdda_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// op: 0 = start segment, 1 = step one pixel
	input  logic                                s_axis_tuser,
	// result beats
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pixel_x (10), pixel_y (10), pixel_color (32), 4 zero bits
	output logic [cdda_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// pixel_write, busy_res
	output logic [cdda_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	// last pixel of a segment, or start of a zero-length one
	output logic                                m_axis_tlast
);
	import cdda_pkg::*;

	logic       queue_full, push, pop, head_valid;
	cdda_cmd_t  cmd, head;
	pix_res_t   res;

	// Front end: classify each beat as step, start, or zero-length start,
	// and precompute the segment deltas.
	cdda_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (queue_full),
		.push          (push),
		.cmd           (cmd)
	);

	// Decouples input flow from the long segment setup in the back end.
	cdda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd_in     (cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: step count = isqrt(dx^2 + dy^2), per-axis Q2.16 increments,
	// then one clipped pixel per step beat from the output register.
	cdda_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.color, res.y, res.x};
	assign m_axis_tuser = {res.busy, res.write};
	assign m_axis_tlast = res.last;

endmodule
